// File: rtl/core/wildcard_byte_pattern_scanner_macros.svh
// ----------------------------------------------------------------------------
// wildcard byte pattern scanner assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WBPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wbps assertion failed");
// next-cycle implication
`define WBPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wbps assertion failed");
`else
`define WBPS_ASSERT_NOW(lbl, ante, cons)
`define WBPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// shared widths, register indexes and the result type of the pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int PATTERN_MAX_DEF  = 16;
	localparam int ADDRESS_BITS_DEF = 32;

	localparam int DATA_W       = 8;
	localparam int MATCH_ADDR_W = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int WILD_W       = 16;
	localparam int PLEN_W       = 5;
	localparam int BASE_W       = 32;

	localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd4;

	typedef struct packed {
		logic                    found;
		logic [MATCH_ADDR_W-1:0] match_address;
	} result_t;

endpackage

// File: rtl/core/wbps_if.sv
// ----------------------------------------------------------------------------
// wbps channel interfaces
// byte input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface wbps_in_if
	import wbps_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              region_last;

	modport source (output valid, output data_byte, output region_last, input ready);
	modport sink (input valid, input data_byte, input region_last, output ready);
endinterface

interface wbps_out_if
	import wbps_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic [MATCH_ADDR_W-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

interface wbps_cfg_if
	import wbps_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// one window byte: holds it, passes it on, compares its incoming byte against its pattern byte
// ----------------------------------------------------------------------------
module wbps_cell #(
	parameter int PATTERN_MAX = 16,
	parameter int IDX         = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift_en,
	input  logic [7:0]                          d_in,
	output logic [7:0]                          d_out,
	input  logic [$clog2(PATTERN_MAX + 1)-1:0]  len,
	input  logic [PATTERN_MAX-1:0][7:0]         pattern,
	input  logic [PATTERN_MAX-1:0]              wild,
	output logic                                hit
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int SEL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [7:0]       byte_q;
	logic             active;
	logic [LEN_W-1:0] sel;
	logic [SEL_W-1:0] sel_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= d_in;
		end
	end

	assign d_out = byte_q;

	// cell j lines up with pattern byte len-1-j
	assign active  = len > LEN_W'(IDX);
	assign sel     = len - LEN_W'(IDX) - LEN_W'(1);
	assign sel_idx = sel[SEL_W-1:0];
	assign hit     = !active || wild[sel_idx] || (d_in == pattern[sel_idx]);

endmodule

// File: rtl/core/wbps_out_skid.sv
// ----------------------------------------------------------------------------
// wbps_out_skid
// two-entry result buffer that drives the output channel
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_macros.svh"

module wbps_out_skid
	import wbps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  result_t           push_data,
	output logic              can_push,
	wbps_out_if.source        out_ch
);

	logic    main_valid_q;
	logic    spare_valid_q;
	result_t main_q;
	result_t spare_q;
	logic    pop;

	assign pop      = main_valid_q && out_ch.ready;
	assign can_push = !spare_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (spare_valid_q) begin
					spare_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				if (main_valid_q) begin
					spare_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= spare_valid_q ? spare_q : push_data;
		end else if (push) begin
			if (main_valid_q) begin
				spare_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign out_ch.valid         = main_valid_q;
	assign out_ch.found         = main_q.found;
	assign out_ch.match_address = main_q.match_address;

	`WBPS_ASSERT_NOW(a_spare_behind_main, spare_valid_q, main_valid_q)
	`WBPS_ASSERT_NOW(a_no_push_when_full, push, !spare_valid_q)
	`WBPS_ASSERT_NEXT(a_spare_moves_up, pop && spare_valid_q, main_valid_q && !spare_valid_q)

endmodule

// File: rtl/core/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// sliding-window search for a masked byte pattern in a byte stream
// ----------------------------------------------------------------------------
// usage
// - in_ch carries one byte of the region per request, region_last on the
//   final byte. out_ch carries at most one result per region: found=1 with
//   the address of the match's first byte (region_base + offset), or
//   found=0 with address 0 when the region ends without a match.
// - cfg_ch writes the registers: 0 pattern bytes 0..7, 1 pattern bytes 8..15,
//   2 wildcard mask, 3 pattern length (0 acts as 1, long values clamp),
//   4 region base. cfg_ch is always ready; write only between regions or
//   while no result is pending.
// - throughput: one byte per cycle while in_ch is ready. the window is
//   a row of byte cells that shift once per scanned byte and compare in
//   parallel against the pattern; compare, match decision and address add
//   happen in the same cycle. the output buffer registers the result of the
//   byte that completes the match (or the last byte of an unmatched region).
// - stall: results sit in a two-entry output buffer; in_ch stays ready while
//   the receiver stalls until a second result is waiting, then drops ready.
// - after a result the rest of the region is drained without compares; the
//   last byte clears the position count for the next region.
// - reset: window cells clear, pattern length goes to 1, all else to 0.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_macros.svh"

module wildcard_byte_pattern_scanner
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wbps_in_if.sink    in_ch,
	wbps_out_if.source out_ch,
	wbps_cfg_if.sink   cfg_ch
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int POS_W = ADDRESS_BITS;

	// configuration registers
	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [WILD_W-1:0]     wild_q;
	logic [PLEN_W-1:0]     plen_q;
	logic [BASE_W-1:0]     base_q;

	// scan state
	logic [POS_W-1:0] pos_q;
	logic             reported_q;

	logic                          accept;
	logic                          scan_en;
	logic [PATTERN_MAX-1:0][7:0]   pat;
	logic [PATTERN_MAX-1:0]        wild;
	logic [PATTERN_MAX-1:0][7:0]   win;
	logic [PATTERN_MAX-1:0]        hit;
	logic [LEN_W-1:0]              len;
	logic [POS_W-1:0]              pos_next;
	logic [POS_W-1:0]              addr;
	logic                          match_now;
	logic                          push;
	result_t                       push_data;
	logic                          can_push;

	// ---------------------------------------------------------------- config
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q   <= '0;
			plen_q   <= PLEN_RESET;
			base_q   <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_PAT_LO: pat_lo_q <= cfg_ch.data;
				REG_PAT_HI: pat_hi_q <= cfg_ch.data;
				REG_WILD:   wild_q   <= cfg_ch.data[WILD_W-1:0];
				REG_PLEN:   plen_q   <= cfg_ch.data[PLEN_W-1:0];
				REG_BASE:   base_q   <= cfg_ch.data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// pattern bytes past sixteen read as 0x00 and are never wild
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
		if (i < 8) begin : g_lo
			assign pat[i]  = pat_lo_q[8*i +: 8];
			assign wild[i] = wild_q[i];
		end else if (i < 16) begin : g_hi
			assign pat[i]  = pat_hi_q[8*(i-8) +: 8];
			assign wild[i] = wild_q[i];
		end else begin : g_zero
			assign pat[i]  = 8'h00;
			assign wild[i] = 1'b0;
		end
	end

	// effective length: zero acts as one, clamp at the window depth
	always_comb begin
		if (plen_q == '0) begin
			len = LEN_W'(1);
		end else if ({3'b000, plen_q} > 8'(PATTERN_MAX)) begin
			len = LEN_W'(PATTERN_MAX);
		end else begin
			len = LEN_W'(plen_q);
		end
	end

	// ---------------------------------------------------------- window cells
	assign accept  = in_ch.valid && in_ch.ready;
	// once a result is out the window freezes until the region ends
	assign scan_en = accept && !reported_q;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		logic [7:0] cell_in;
		if (j == 0) begin : g_head
			assign cell_in = in_ch.data_byte;
		end else begin : g_link
			assign cell_in = win[j-1];
		end
		wbps_cell #(
			.PATTERN_MAX (PATTERN_MAX),
			.IDX         (j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (scan_en),
			.d_in     (cell_in),
			.d_out    (win[j]),
			.len      (len),
			.pattern  (pat),
			.wild     (wild),
			.hit      (hit[j])
		);
	end

	// ------------------------------------------------------ match / address
	// position saturates at all ones
	assign pos_next  = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
	// cells below len must all hold bytes of this region
	assign match_now = (&hit) && (pos_next >= POS_W'(len));
	assign addr      = POS_W'(base_q) + pos_next - POS_W'(len);

	assign push                    = scan_en && (match_now || in_ch.region_last);
	assign push_data.found         = match_now;
	assign push_data.match_address = match_now ? MATCH_ADDR_W'(addr) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (in_ch.region_last) begin
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else if (scan_en) begin
				pos_q <= pos_next;
				if (match_now) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------- result path
	wbps_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.can_push  (can_push),
		.out_ch    (out_ch)
	);

	assign in_ch.ready = can_push;

	`WBPS_ASSERT_NOW(a_push_needs_request, push, accept)
	`WBPS_ASSERT_NOW(a_one_result_per_region, accept && reported_q, !push)
	`WBPS_ASSERT_NEXT(a_last_clears_scan, accept && in_ch.region_last,
		pos_q == '0 && !reported_q)
	`WBPS_ASSERT_NEXT(a_match_marks_reported, push && match_now && !in_ch.region_last,
		reported_q)

endmodule
